FILE: sv/ctp_pkg.sv
// Shared types, register codes and helpers of the CSR threshold prune block.
package ctp_pkg;

  localparam int REG_IDX_W = 2;
  localparam int FILL_MAX_W = 6;

  localparam logic [REG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BASE      = 2'd2;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_ROW   = 2'd1;
  localparam logic [1:0] MODE_PEAK  = 2'd2;

  typedef enum logic [1:0] {
    ENT_NONE,
    ENT_KEEP,
    ENT_DROP
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t             kind;
    logic [30:0]           col;
    logic [31:0]           val;
    logic                  row_end;
    logic [FILL_MAX_W-1:0] fill;
    logic [30:0]           peak;
    logic                  ovf;
  } ctp_cmd_t;

  typedef struct packed {
    logic        is_pointer;
    logic [30:0] col;
    logic [31:0] val;
    logic [31:0] ptr;
    logic [31:0] removed;
    logic        ovf;
    logic        last;
  } ctp_res_t;

  function automatic logic [30:0] ctp_mag(input logic [31:0] v);
    logic [31:0] neg;
    neg = 32'd0 - v;
    if (!v[31]) begin
      return v[30:0];
    end else if (v == 32'h8000_0000) begin
      return 31'h7FFF_FFFF;
    end else begin
      return neg[30:0];
    end
  endfunction

endpackage

FILE: sv/ctp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctp_ram #(
  parameter int W     = 63,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: sv/ctp_queue.sv
// Small first-in first-out queue of words.
module ctp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int PW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/ctp_front.sv
// Front end: accepts items, judges direct entries, fills the row buffer.
module ctp_front import ctp_pkg::*; #(
  parameter int ROW_CAP = 32,
  parameter int CW      = 31,
  localparam int FW     = $clog2(ROW_CAP + 1),
  localparam int AW     = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic           has_entry,
  input  logic [30:0]    entry_col,
  input  logic [31:0]    entry_value,
  input  logic           row_last,
  input  logic [31:0]    row_limit,
  input  logic [1:0]     mode,
  input  logic [31:0]    threshold,
  input  logic           q_full,
  output logic           cmd_push,
  output ctp_cmd_t       cmd,
  input  logic           row_done,
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output logic [CW+31:0] ram_wdata
);

  logic [FW-1:0] fill_r, fill_nxt;
  logic [30:0]   peak_r, peak_nxt;
  logic          ovf_r, ovf_nxt;
  logic          wait_r;
  logic          acc;
  logic          buffered;
  logic          space;
  logic [30:0]   mag;
  logic [31:0]   th;
  logic [30:0]   col_m;

  assign full     = q_full || wait_r;
  assign acc      = push && !full;
  assign mag      = ctp_mag(entry_value);
  assign th       = (mode == MODE_ROW) ? row_limit : threshold;
  assign buffered = has_entry && ((mode == MODE_PEAK) || (fill_r != '0));
  assign space    = (fill_r < FW'(ROW_CAP));
  assign col_m    = 31'(entry_col[CW-1:0]);

  assign ram_we    = acc && buffered && space;
  assign ram_waddr = fill_r[AW-1:0];
  assign ram_wdata = {entry_col[CW-1:0], entry_value};

  always_comb begin
    fill_nxt = fill_r;
    peak_nxt = peak_r;
    ovf_nxt  = ovf_r;
    if (buffered) begin
      if (space) begin
        fill_nxt = fill_r + 1'b1;
        if (mag > peak_r) begin
          peak_nxt = mag;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    cmd.col     = col_m;
    cmd.val     = entry_value;
    cmd.row_end = row_last;
    cmd.fill    = FILL_MAX_W'(fill_nxt);
    cmd.peak    = peak_nxt;
    cmd.ovf     = ovf_nxt;
    if (!has_entry) begin
      cmd.kind = ENT_NONE;
    end else if (buffered) begin
      cmd.kind = space ? ENT_NONE : ENT_DROP;
    end else begin
      cmd.kind = ({1'b0, mag} > th) ? ENT_KEEP : ENT_DROP;
    end
  end

  assign cmd_push = acc && ((cmd.kind != ENT_NONE) || row_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      peak_r <= '0;
      ovf_r  <= 1'b0;
      wait_r <= 1'b0;
    end else begin
      if (acc && row_last) begin
        fill_r <= '0;
        peak_r <= '0;
        ovf_r  <= 1'b0;
        wait_r <= 1'b1;
      end else if (acc) begin
        fill_r <= fill_nxt;
        peak_r <= peak_nxt;
        ovf_r  <= ovf_nxt;
      end
      if (row_done) begin
        wait_r <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/ctp_back.sv
// Back end: emits entry words, drains the row buffer, writes row pointers.
module ctp_back import ctp_pkg::*; #(
  parameter int ROW_CAP = 32,
  parameter int CW      = 31,
  localparam int FW     = $clog2(ROW_CAP + 1),
  localparam int AW     = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  ctp_cmd_t       cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output ctp_res_t       res,
  output logic           row_done,
  output logic           ram_re,
  output logic [AW-1:0]  ram_raddr,
  input  logic [CW+31:0] ram_rdata,
  input  logic [31:0]    threshold,
  input  logic           base_index
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENT,
    S_MUL,
    S_RD,
    S_CHK,
    S_PTR
  } state_t;

  state_t        state_r;
  ctp_cmd_t      cur_r;
  logic [46:0]   lim_r;
  logic [FW-1:0] idx_r;
  logic [31:0]   kept_r;
  logic [31:0]   dropped_r;
  logic [62:0]   prod;
  logic          hit;
  logic          idx_end;

  assign prod      = 63'(cur_r.peak) * 63'(threshold);
  assign hit       = {16'd0, ctp_mag(ram_rdata[31:0])} > lim_r;
  assign idx_end   = ((idx_r + FW'(1)) == cur_r.fill[FW-1:0]);
  assign ram_raddr = idx_r[AW-1:0];

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res      = '0;
    row_done = 1'b0;
    ram_re   = 1'b0;
    unique case (state_r)
      S_IDLE: cmd_pop = !cmd_empty;
      S_ENT: begin
        res.col  = cur_r.col;
        res.val  = cur_r.val;
        res.last = !cur_r.row_end;
        res_push = (cur_r.kind == ENT_KEEP) && !res_full;
      end
      S_MUL: ;
      S_RD: ram_re = 1'b1;
      S_CHK: begin
        res.col  = 31'(ram_rdata[CW+31:32]);
        res.val  = ram_rdata[31:0];
        res_push = hit && !res_full;
      end
      S_PTR: begin
        res.is_pointer = 1'b1;
        res.ptr        = 32'(base_index) + kept_r;
        res.removed    = dropped_r;
        res.ovf        = cur_r.ovf;
        res.last       = 1'b1;
        res_push       = !res_full;
        row_done       = !res_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      kept_r    <= '0;
      dropped_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            cur_r   <= cmd;
            state_r <= S_ENT;
          end
        end
        S_ENT: begin
          if (!((cur_r.kind == ENT_KEEP) && res_full)) begin
            if (cur_r.kind == ENT_KEEP) begin
              kept_r <= kept_r + 1'b1;
            end
            if (cur_r.kind == ENT_DROP) begin
              dropped_r <= dropped_r + 1'b1;
            end
            state_r <= cur_r.row_end ? S_MUL : S_IDLE;
          end
        end
        S_MUL: begin
          lim_r   <= prod[62:16];
          idx_r   <= '0;
          state_r <= (cur_r.fill == '0) ? S_PTR : S_RD;
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (!(hit && res_full)) begin
            if (hit) begin
              kept_r <= kept_r + 1'b1;
            end else begin
              dropped_r <= dropped_r + 1'b1;
            end
            if (idx_end) begin
              state_r <= S_PTR;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_PTR: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/csr_threshold_prune.sv
// Top level of the CSR magnitude threshold prune block.
// A direct entry word goes through the command queue, back-end states S_IDLE and S_ENT, and
// the result queue. Each item takes S_IDLE and S_ENT; a row end adds S_MUL for the product
// of peak and fraction, S_RD/S_CHK (RAM read, judge) per buffered entry, S_PTR for the pointer.
// Input stalls from a row-end accept until that row's pointer word is written.
// Reset clears control registers, counters and queues; row RAM and back-end data are not cleared.
module csr_threshold_prune import ctp_pkg::*; #(
  parameter int ROW_CAP  = 32,
  parameter int COL_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_has_entry,
  input  logic [30:0]          in_entry_col,
  input  logic signed [31:0]   in_entry_value,
  input  logic                 in_row_last,
  input  logic [31:0]          in_row_limit,
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_is_pointer,
  output logic [30:0]          out_col,
  output logic signed [31:0]   out_value,
  output logic [31:0]          out_row_end_pointer,
  output logic [31:0]          out_removed_total,
  output logic                 out_row_overflow,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int CW = (COL_BITS < 31) ? COL_BITS : 31;
  localparam int AW = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;

  logic [1:0]  mode_r;
  logic [31:0] thr_r;
  logic        base_r;

  ctp_cmd_t       cmd_in, cmd_out;
  logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
  ctp_res_t       res_in, res_out;
  logic           res_push, res_full;
  logic           row_done;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [CW+31:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIXED;
      thr_r  <= '0;
      base_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode_r <= cfg_wdata[1:0];
        REG_THRESHOLD: thr_r  <= cfg_wdata;
        REG_BASE:      base_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ctp_front #(.ROW_CAP(ROW_CAP), .CW(CW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .has_entry     (in_has_entry),
    .entry_col     (in_entry_col),
    .entry_value   (in_entry_value),
    .row_last      (in_row_last),
    .row_limit     (in_row_limit),
    .mode          (mode_r),
    .threshold     (thr_r),
    .q_full        (cmd_full),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .row_done      (row_done),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  ctp_queue #(.W($bits(ctp_cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  ctp_ram #(.W(CW + 32), .DEPTH(ROW_CAP)) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ctp_back #(.ROW_CAP(ROW_CAP), .CW(CW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .row_done   (row_done),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .threshold  (thr_r),
    .base_index (base_r)
  );

  ctp_queue #(.W($bits(ctp_res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_out),
    .full  (res_full),
    .empty (empty)
  );

  assign out_is_pointer      = res_out.is_pointer;
  assign out_col             = res_out.col;
  assign out_value           = res_out.val;
  assign out_row_end_pointer = res_out.ptr;
  assign out_removed_total   = res_out.removed;
  assign out_row_overflow    = res_out.ovf;
  assign out_last            = res_out.last;

  a_ptr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_pointer) |-> out_last)
    else $error("pointer word without last");

  a_ptr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_pointer) |-> (out_col == '0 && out_value == '0))
    else $error("pointer word carries entry fields");

  a_ent_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_is_pointer) |->
      (out_row_end_pointer == '0 && out_removed_total == '0 && !out_row_overflow))
    else $error("entry word carries pointer fields");

  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_row_last) |=> full)
    else $error("input not held after row end");

endmodule

FILE: tb/tb.sv
// Testbench for csr_threshold_prune: directed and random CSR rows checked against a local model.
`timescale 1ns / 1ps

module tb import ctp_pkg::*; ;

  localparam int ROW_CAP = 32;
  localparam logic [1:0] MODE_FIXED_ALIAS = 2'd3;

  typedef struct packed {
    logic        has;
    logic [30:0] col;
    logic [31:0] val;
    logic        row_last;
    logic [31:0] rthr;
  } prune_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  logic                 in_has_entry;
  logic [30:0]          in_entry_col;
  logic signed [31:0]   in_entry_value;
  logic                 in_row_last;
  logic [31:0]          in_row_limit;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 out_is_pointer;
  logic [30:0]          out_col;
  logic signed [31:0]   out_value;
  logic [31:0]          out_row_end_pointer;
  logic [31:0]          out_removed_total;
  logic                 out_row_overflow;
  logic                 out_last;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  csr_threshold_prune uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_has_entry        (in_has_entry),
    .in_entry_col        (in_entry_col),
    .in_entry_value      (in_entry_value),
    .in_row_last         (in_row_last),
    .in_row_limit        (in_row_limit),
    .empty               (empty),
    .pop                 (pop),
    .out_is_pointer      (out_is_pointer),
    .out_col             (out_col),
    .out_value           (out_value),
    .out_row_end_pointer (out_row_end_pointer),
    .out_removed_total   (out_removed_total),
    .out_row_overflow    (out_row_overflow),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  // model state
  logic [1:0]  reg_mode = 2'd0;
  logic [31:0] reg_thr = 32'd0;
  logic        reg_base = 1'b0;
  logic [30:0] row_cols_m [ROW_CAP];
  logic [31:0] row_vals_m [ROW_CAP];
  int          row_fill = 0;
  logic [30:0] row_peak = 31'd0;
  logic [31:0] kept_cnt = 32'd0;
  logic [31:0] dropped_cnt = 32'd0;
  logic        ovf_seen = 1'b0;

  ctp_res_t    due_words [$];
  ctp_res_t    tail_word;
  bit          tail_valid = 1'b0;

  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          pop_pct = 100;
  int          recv_cyc = 0;

  function automatic logic [30:0] abs_sat(input logic [31:0] v);
    logic [31:0] neg;
    neg = 32'd0 - v;
    if (v == 32'h8000_0000) return 31'h7FFF_FFFF;
    return v[31] ? neg[30:0] : v[30:0];
  endfunction

  function automatic void queue_word(input logic is_ptr, input logic [30:0] col,
                                     input logic [31:0] val, input logic [31:0] ptr,
                                     input logic [31:0] rem, input logic ovf);
    if (tail_valid) due_words.push_back(tail_word);
    tail_word.is_pointer = is_ptr;
    tail_word.col        = col;
    tail_word.val        = val;
    tail_word.ptr        = ptr;
    tail_word.removed    = rem;
    tail_word.ovf        = ovf;
    tail_word.last       = 1'b0;
    tail_valid           = 1'b1;
  endfunction

  function automatic void prune_item(input prune_item_t it);
    logic [30:0] a;
    logic [31:0] th;
    logic [63:0] lim;
    if (it.has) begin
      a = abs_sat(it.val);
      if (reg_mode == MODE_PEAK || row_fill != 0) begin
        if (row_fill < ROW_CAP) begin
          row_cols_m[row_fill] = it.col;
          row_vals_m[row_fill] = it.val;
          row_fill++;
          if (a > row_peak) row_peak = a;
        end else begin
          dropped_cnt++;
          ovf_seen = 1'b1;
        end
      end else begin
        th = (reg_mode == MODE_ROW) ? it.rthr : reg_thr;
        if ({1'b0, a} > th) begin
          queue_word(1'b0, it.col, it.val, 32'd0, 32'd0, 1'b0);
          kept_cnt++;
        end else begin
          dropped_cnt++;
        end
      end
    end
    if (it.row_last) begin
      lim = ({33'd0, row_peak} * {32'd0, reg_thr}) >> 16;
      for (int i = 0; i < row_fill; i++) begin
        if ({33'd0, abs_sat(row_vals_m[i])} > lim) begin
          queue_word(1'b0, row_cols_m[i], row_vals_m[i], 32'd0, 32'd0, 1'b0);
          kept_cnt++;
        end else begin
          dropped_cnt++;
        end
      end
      queue_word(1'b1, 31'd0, 32'd0, {31'd0, reg_base} + kept_cnt, dropped_cnt, ovf_seen);
      row_fill = 0;
      row_peak = 31'd0;
      ovf_seen = 1'b0;
    end
    if (tail_valid) begin
      tail_word.last = 1'b1;
      due_words.push_back(tail_word);
      tail_valid = 1'b0;
    end
  endfunction

  function automatic void cmp_field(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : word_check
    ctp_res_t w;
    if (rst_n === 1'b1 && pop && !empty) begin
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none actual ptr=%b col=%h val=%h",
                 $time, out_is_pointer, out_col, out_value);
      end else begin
        w = due_words.pop_front();
        cmp_field("is_pointer", {31'd0, w.is_pointer}, {31'd0, out_is_pointer});
        cmp_field("col", {1'b0, w.col}, {1'b0, out_col});
        cmp_field("value", w.val, out_value);
        cmp_field("row_end_pointer", w.ptr, out_row_end_pointer);
        cmp_field("removed_total", w.removed, out_removed_total);
        cmp_field("row_overflow", {31'd0, w.ovf}, {31'd0, out_row_overflow});
        cmp_field("last", {31'd0, w.last}, {31'd0, out_last});
      end
    end
  end

  // receiver: phased pop rate, long hold on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    recv_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (recv_cyc % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pop_pct = 100;
          1: pop_pct = 80;
          2: pop_pct = 50;
          default: pop_pct = 15;
        endcase
      end
      pop <= ($urandom_range(0, 99) < pop_pct);
    end
  end

  function automatic prune_item_t mk_item(input logic has, input logic [30:0] col,
                                          input logic [31:0] val, input logic row_last,
                                          input logic [31:0] rthr);
    prune_item_t it;
    it.has      = has;
    it.col      = col;
    it.val      = val;
    it.row_last = row_last;
    it.rthr     = rthr;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4, 5: return 32'd0 - $urandom_range(1, 32'h30000);
      default: return $urandom_range(1, 32'h30000);
    endcase
  endfunction

  function automatic logic [31:0] rand_thr();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3, 4: return $urandom_range(32'h4000, 32'h10000);
      default: return $urandom_range(0, 32'h40000);
    endcase
  endfunction

  task automatic send_item(input prune_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push             <= 1'b1;
    in_has_entry     <= it.has;
    in_entry_col     <= it.col;
    in_entry_value   <= it.val;
    in_row_last      <= it.row_last;
    in_row_limit     <= it.rthr;
    do @(posedge clk); while (full);
    prune_item(it);
    if (it.has || it.row_last) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_drained();
    repeat (16) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: reg_mode = data[1:0];
      REG_THRESHOLD: reg_thr = data;
      REG_BASE: reg_base = data[0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [1:0] m, input logic [31:0] thr, input logic base);
    write_reg(REG_MODE, ($urandom & 32'hFFFF_FFFC) | {30'd0, m});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_BASE, ($urandom & 32'hFFFF_FFFE) | {31'd0, base});
  endtask

  task automatic send_row(input int len);
    logic [31:0] rth;
    bit tail_empty;
    rth = rand_thr();
    tail_empty = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(mk_item(1'b0, 31'($urandom), $urandom, 1'b0, $urandom));
      if ($urandom_range(0, 3) == 0) rth = rand_thr();
      send_item(mk_item(1'b1, 31'($urandom), rand_value(), (k == len - 1) && !tail_empty,
                        rth));
    end
    if (tail_empty) send_item(mk_item(1'b0, 31'($urandom), $urandom, 1'b1, rth));
  endtask

  task automatic test_fixed_threshold();
    set_cfg(MODE_FIXED, 32'h0001_0000, 1'b0);
    send_item(mk_item(1'b1, 31'd0, 32'h0001_0000, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'h7FFF_FFFF, 32'h0001_0001, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd5, 32'hFFFE_FFFF, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd6, 32'h8000_0000, 1'b0, 32'd0));
    send_item(mk_item(1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    send_item(mk_item(1'b1, 31'd7, 32'd0, 1'b1, 32'd0));
    send_item(mk_item(1'b0, 31'd0, 32'd0, 1'b1, 32'd0));
  endtask

  task automatic test_row_threshold();
    set_cfg(MODE_ROW, 32'hFFFF_FFFF, 1'b0);
    send_item(mk_item(1'b1, 31'd1, 32'd1, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd2, 32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    send_item(mk_item(1'b1, 31'd3, 32'h8000_0000, 1'b0, 32'h7FFF_FFFE));
    send_item(mk_item(1'b1, 31'd4, 32'd0, 1'b1, 32'd0));
  endtask

  task automatic test_row_peak();
    set_cfg(MODE_PEAK, 32'h0000_8000, 1'b0);
    send_item(mk_item(1'b1, 31'd10, 32'h0004_0000, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd11, 32'hFFFF_0000, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd12, 32'h0002_0001, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd13, 32'h0002_0000, 1'b1, 32'd0));
    send_item(mk_item(1'b1, 31'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd1, 32'h3FFF_FFFF, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd2, 32'h4000_0000, 1'b1, 32'd0));
    send_item(mk_item(1'b0, 31'd0, 32'd0, 1'b1, 32'd0));
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    send_item(mk_item(1'b1, 31'd3, 32'h0000_0010, 1'b1, 32'd0));
  endtask

  task automatic test_mode_three();
    set_cfg(MODE_FIXED_ALIAS, 32'd0, 1'b0);
    send_item(mk_item(1'b1, 31'd9, 32'd1, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_mode_switch_mid_row();
    set_cfg(MODE_PEAK, 32'd0, 1'b0);
    send_item(mk_item(1'b1, 31'd20, 32'd5, 1'b0, 32'd0));
    write_reg(REG_MODE, {30'd0, MODE_FIXED});
    send_item(mk_item(1'b1, 31'd21, 32'hFFFF_FFFF, 1'b0, 32'd0));
    send_item(mk_item(1'b0, 31'd0, 32'd0, 1'b1, 32'd0));
    write_reg(REG_THRESHOLD, 32'h0001_0000);
    send_item(mk_item(1'b1, 31'd22, 32'h0002_0000, 1'b0, 32'd0));
    write_reg(REG_MODE, {30'd0, MODE_PEAK});
    send_item(mk_item(1'b1, 31'd23, 32'h0000_0010, 1'b0, 32'd0));
    send_item(mk_item(1'b1, 31'd24, 32'h0003_0000, 1'b1, 32'd0));
  endtask

  task automatic test_base_index();
    set_cfg(MODE_FIXED, 32'd0, 1'b1);
    send_item(mk_item(1'b1, 31'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'd0));
    send_item(mk_item(1'b0, 31'd0, 32'd0, 1'b1, 32'd0));
  endtask

  task automatic test_row_overflow();
    set_cfg(MODE_PEAK, $urandom_range(0, 32'h10000), 1'b0);
    send_row(ROW_CAP + 1);
    send_row($urandom_range(ROW_CAP + 2, ROW_CAP + 4));
  endtask

  task automatic test_output_backpressure();
    set_cfg(MODE_FIXED, 32'd0, 1'b1);
    hold_req = 300;
    repeat (8) send_row(4);
    wait_drained();
  endtask

  task automatic test_random_rows();
    int len;
    while (items_sent < 200) begin
      set_cfg(2'($urandom_range(0, 3)), rand_thr(), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 8)) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        send_row(len);
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    push             = 1'b0;
    in_has_entry     = 1'b0;
    in_entry_col     = 31'd0;
    in_entry_value   = 32'sd0;
    in_row_last      = 1'b0;
    in_row_limit     = 32'd0;
    cfg_we           = 1'b0;
    cfg_index        = REG_MODE;
    cfg_wdata        = 32'd0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_fixed_threshold();
    test_row_threshold();
    test_row_peak();
    test_mode_three();
    test_mode_switch_mid_row();
    test_base_index();
    test_row_overflow();
    test_output_backpressure();
    test_random_rows();

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d words outstanding", due_words.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ctp_pkg.sv
sv/ctp_ram.sv
sv/ctp_queue.sv
sv/ctp_front.sv
sv/ctp_back.sv
sv/csr_threshold_prune.sv
tb/tb.sv
